FILE: rtl/assert_macros.svh
// Assertion macros shared by the semaphore table RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH
// Property that must hold in the same cycle as its antecedent.
`define CST_ASSERT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
// Property whose consequent must hold in the cycle after its antecedent.
`define CST_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define CST_ASSERT(lbl, ante, cons, msg)
`define CST_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/cst_pkg.sv
// Types and constants shared by the semaphore table controller and datapath.
package cst_pkg;

    localparam int NUM_SEMS_DEF = 8;
    localparam int WAITERS_DEF  = 8;
    localparam int ID_W         = 16;
    localparam int CMD_W        = 2;
    localparam int STATUS_W     = 4;

    typedef enum logic [CMD_W-1:0] {
        CMD_CREATE = 2'd0,
        CMD_WAIT   = 2'd1,
        CMD_POST   = 2'd2,
        CMD_KILL   = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        STAT_CREATED   = 4'd0,
        STAT_GRANTED   = 4'd1,
        STAT_BLOCKED   = 4'd2,
        STAT_POSTED    = 4'd3,
        STAT_WOKEN     = 4'd4,
        STAT_KILLED    = 4'd5,
        STAT_NOTFOUND  = 4'd6,
        STAT_TABLEFULL = 4'd7,
        STAT_QUEUEFULL = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        FSM_IDLE,
        FSM_SCAN,
        FSM_DECIDE,
        FSM_DUP,
        FSM_POP,
        FSM_DRAIN,
        FSM_FIN
    } fsm_t;

    // Action the datapath performs in the current cycle; every action but
    // ACT_NONE writes one result item.
    typedef enum logic [3:0] {
        ACT_NONE,
        ACT_CREATE,
        ACT_TFULL,
        ACT_NFOUND,
        ACT_GRANT,
        ACT_BLOCK,
        ACT_ENQ,
        ACT_QFULL,
        ACT_POSTED,
        ACT_WAKE_POST,
        ACT_WAKE_KILL,
        ACT_KILLED
    } act_t;

    typedef struct packed {
        logic load;
        logic scan_run;
        logic pos_clr;
        logic wrun;
        act_t act;
    } ctrl_t;

    typedef struct packed {
        cmd_t cmd;
        logic hit;
        logic miss;
        logic cnt_pos;
        logic fill_zero;
        logic fill_full;
        logic post_wake;
        logic dup_hit;
        logic dup_end;
        logic wq_vld;
        logic wq_last;
    } dp_stat_t;

endpackage

FILE: rtl/cst_ctrl.sv
// Sequencing state machine of the semaphore table.
`include "assert_macros.svh"

module cst_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    output logic              busy,
    input  cst_pkg::dp_stat_t stat,
    output cst_pkg::ctrl_t    ctrl
);
    import cst_pkg::*;

    fsm_t state_reg;
    fsm_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= FSM_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            FSM_IDLE:
            begin
                if (start)
                begin
                    state_next = FSM_SCAN;
                end
            end
            FSM_SCAN:
            begin
                if (stat.hit)
                begin
                    state_next = (stat.cmd == CMD_CREATE) ? FSM_IDLE : FSM_DECIDE;
                end
                else if (stat.miss)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_DECIDE:
            begin
                case (stat.cmd)
                    CMD_WAIT:
                    begin
                        state_next = (stat.cnt_pos || stat.fill_zero) ? FSM_IDLE : FSM_DUP;
                    end
                    CMD_POST:
                    begin
                        state_next = stat.post_wake ? FSM_POP : FSM_IDLE;
                    end
                    CMD_KILL:
                    begin
                        state_next = stat.fill_zero ? FSM_IDLE : FSM_DRAIN;
                    end
                    default:
                    begin
                        state_next = FSM_IDLE;
                    end
                endcase
            end
            FSM_DUP:
            begin
                if (stat.dup_hit || stat.dup_end)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_POP:
            begin
                if (stat.wq_vld)
                begin
                    state_next = FSM_IDLE;
                end
            end
            FSM_DRAIN:
            begin
                if (stat.wq_last)
                begin
                    state_next = FSM_FIN;
                end
            end
            FSM_FIN:
            begin
                state_next = FSM_IDLE;
            end
            default:
            begin
                state_next = FSM_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctrl = '{load: 1'b0, scan_run: 1'b0, pos_clr: 1'b0, wrun: 1'b0, act: ACT_NONE};
        busy = 1'b1;
        case (state_reg)
            FSM_IDLE:
            begin
                busy      = 1'b0;
                ctrl.load = start;
            end
            FSM_SCAN:
            begin
                ctrl.scan_run = 1'b1;
                if (stat.hit && stat.cmd == CMD_CREATE)
                begin
                    ctrl.act = ACT_CREATE;
                end
                else if (stat.miss)
                begin
                    ctrl.act = (stat.cmd == CMD_CREATE) ? ACT_TFULL : ACT_NFOUND;
                end
            end
            FSM_DECIDE:
            begin
                ctrl.pos_clr = 1'b1;
                case (stat.cmd)
                    CMD_WAIT:
                    begin
                        if (stat.cnt_pos)
                        begin
                            ctrl.act = ACT_GRANT;
                        end
                        else if (stat.fill_zero)
                        begin
                            ctrl.act = ACT_ENQ;
                        end
                    end
                    CMD_POST:
                    begin
                        if (!stat.post_wake)
                        begin
                            ctrl.act = ACT_POSTED;
                        end
                    end
                    CMD_KILL:
                    begin
                        if (stat.fill_zero)
                        begin
                            ctrl.act = ACT_KILLED;
                        end
                    end
                    default:
                    begin
                        ctrl.act = ACT_NONE;
                    end
                endcase
            end
            FSM_DUP:
            begin
                ctrl.wrun = 1'b1;
                if (stat.dup_hit)
                begin
                    ctrl.act = ACT_BLOCK;
                end
                else if (stat.dup_end)
                begin
                    ctrl.act = stat.fill_full ? ACT_QFULL : ACT_ENQ;
                end
            end
            FSM_POP:
            begin
                ctrl.wrun = 1'b1;
                if (stat.wq_vld)
                begin
                    ctrl.act = ACT_WAKE_POST;
                end
            end
            FSM_DRAIN:
            begin
                ctrl.wrun = 1'b1;
                if (stat.wq_vld)
                begin
                    ctrl.act = ACT_WAKE_KILL;
                end
            end
            FSM_FIN:
            begin
                ctrl.act = ACT_KILLED;
            end
            default:
            begin
                ctrl.act = ACT_NONE;
            end
        endcase
    end

    // Every command ends with the action that writes its final item.
    `CST_ASSERT(a_idle_after_act, state_reg == FSM_IDLE && $past(state_reg) != FSM_IDLE, $past(ctrl.act) != ACT_NONE, "returned to idle without a result")
    `CST_ASSERT_NEXT(a_drain_continues, ctrl.act == ACT_WAKE_KILL, state_reg == FSM_DRAIN || state_reg == FSM_FIN, "kill drain lost its final item")
    `CST_ASSERT(a_queue_walk_entry, (state_reg == FSM_DUP || state_reg == FSM_POP || state_reg == FSM_DRAIN) && $past(state_reg) != state_reg, $past(state_reg) == FSM_DECIDE, "queue walk entered without a decision")

endmodule

FILE: rtl/cst_dp.sv
// Datapath of the semaphore table: slot lookup, slot and queue stores, results.
`include "assert_macros.svh"

module cst_dp #(
    parameter int NUM_SEMS = cst_pkg::NUM_SEMS_DEF,
    parameter int WAITERS  = cst_pkg::WAITERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  cst_pkg::ctrl_t                ctrl,
    output cst_pkg::dp_stat_t             stat,
    input  logic [cst_pkg::CMD_W-1:0]     command,
    input  logic [cst_pkg::ID_W-1:0]      target_id,
    input  logic [cst_pkg::ID_W-1:0]      process_id,
    input  logic [cst_pkg::ID_W-1:0]      initial_value,
    output logic                          done,
    output logic [cst_pkg::STATUS_W-1:0]  status,
    output logic [cst_pkg::ID_W-1:0]      result_id,
    output logic [cst_pkg::ID_W-1:0]      woken_pid,
    output logic                          last_of_run
);
    import cst_pkg::*;

    localparam int SW = (NUM_SEMS > 1) ? $clog2(NUM_SEMS) : 1;
    localparam int IW = $clog2(NUM_SEMS + 1);
    localparam int PW = $clog2(WAITERS + 1);
    localparam int HW = (WAITERS > 1) ? $clog2(WAITERS) : 1;
    localparam int QD = NUM_SEMS * WAITERS;
    localparam int AW = (QD > 1) ? $clog2(QD) : 1;

    typedef struct packed {
        logic [ID_W-1:0] count;
        logic [HW-1:0]   head;
        logic [PW-1:0]   fill;
    } info_t;

    // Latched command.
    cmd_t            cmd_reg;
    logic [ID_W-1:0] id_reg;
    logic [ID_W-1:0] pid_reg;
    logic [ID_W-1:0] init_reg;

    // Slot scan: one slot probed per cycle, compared in the next cycle.
    logic [IW-1:0]   scan_idx_reg;
    logic            pr_vld_reg;
    logic [SW-1:0]   pr_idx_reg;
    logic [ID_W-1:0] pr_tag_reg;
    logic            pr_used_reg;
    logic            scan_ok;
    logic [SW-1:0]   scan_addr;
    logic            match;
    logic            hit;

    logic            used_reg [NUM_SEMS];
    logic [ID_W-1:0] tag_mem  [NUM_SEMS];
    info_t           info_mem [NUM_SEMS];
    info_t           info_rd_reg;
    info_t           info_wd;
    logic            info_we;
    logic [SW-1:0]   slot_reg;
    logic [SW-1:0]   info_addr;
    logic [SW-1:0]   wslot;

    // Waiter queue walk.
    logic [ID_W-1:0] wmem [QD];
    logic [PW-1:0]   pos_reg;
    logic            wq_vld_reg;
    logic [PW-1:0]   wq_pos_reg;
    logic [ID_W-1:0] wq_data_reg;
    logic            w_ok;
    logic [PW:0]     rd_sum;
    logic [PW:0]     wr_sum;
    logic [HW-1:0]   rd_ent;
    logic [HW-1:0]   wr_ent;
    logic [AW-1:0]   base;
    logic [AW-1:0]   rd_addr;
    logic [AW-1:0]   wr_addr;

    logic [ID_W-1:0] new_post;
    logic [HW-1:0]   head_inc;

    logic [ID_W-1:0] next_tag_reg;
    logic            done_reg;
    logic            done_next;
    status_t         status_reg;
    status_t         status_next;
    logic [ID_W-1:0] rid_reg;
    logic [ID_W-1:0] rid_next;
    logic [ID_W-1:0] wpid_reg;
    logic [ID_W-1:0] wpid_next;
    logic            last_reg;
    logic            last_next;

    always_ff @(posedge clk)
    begin
        if (ctrl.load)
        begin
            cmd_reg  <= cmd_t'(command);
            id_reg   <= target_id;
            pid_reg  <= process_id;
            init_reg <= initial_value;
        end
    end

    assign scan_ok   = ctrl.scan_run && (scan_idx_reg < IW'(NUM_SEMS));
    assign scan_addr = scan_idx_reg[SW-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_idx_reg <= '0;
            pr_vld_reg   <= 1'b0;
        end
        else
        begin
            if (ctrl.load)
            begin
                scan_idx_reg <= '0;
            end
            else if (scan_ok)
            begin
                scan_idx_reg <= scan_idx_reg + IW'(1);
            end
            pr_vld_reg <= scan_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (scan_ok)
        begin
            pr_idx_reg  <= scan_addr;
            pr_used_reg <= used_reg[scan_addr];
        end
    end

    assign match = (cmd_reg == CMD_CREATE) ? !pr_used_reg
                                           : (pr_used_reg && pr_tag_reg == id_reg);
    assign hit   = ctrl.scan_run && pr_vld_reg && match;

    assign wslot     = (ctrl.act == ACT_CREATE) ? pr_idx_reg : slot_reg;
    assign info_addr = hit ? pr_idx_reg : slot_reg;

    always_ff @(posedge clk)
    begin
        if (hit)
        begin
            slot_reg <= pr_idx_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.act == ACT_CREATE)
        begin
            tag_mem[wslot] <= next_tag_reg;
        end
        if (scan_ok)
        begin
            pr_tag_reg <= tag_mem[scan_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_SEMS; i++)
            begin
                used_reg[i] <= 1'b0;
            end
        end
        else if (ctrl.act == ACT_CREATE)
        begin
            used_reg[wslot] <= 1'b1;
        end
        else if (ctrl.act == ACT_KILLED)
        begin
            used_reg[wslot] <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (info_we)
        begin
            info_mem[wslot] <= info_wd;
        end
        info_rd_reg <= info_mem[info_addr];
    end

    assign new_post = (info_rd_reg.count == {ID_W{1'b1}}) ? info_rd_reg.count
                                                           : info_rd_reg.count + ID_W'(1);
    assign head_inc = (info_rd_reg.head == HW'(WAITERS - 1)) ? '0
                                                              : info_rd_reg.head + HW'(1);

    always_comb
    begin
        info_we = 1'b1;
        info_wd = info_rd_reg;
        case (ctrl.act)
            ACT_CREATE:
            begin
                info_wd = '{count: init_reg, head: '0, fill: '0};
            end
            ACT_GRANT:
            begin
                info_wd.count = info_rd_reg.count - ID_W'(1);
            end
            ACT_ENQ:
            begin
                info_wd.fill = info_rd_reg.fill + PW'(1);
            end
            ACT_POSTED:
            begin
                info_wd.count = new_post;
            end
            ACT_WAKE_POST:
            begin
                info_wd.count = new_post;
                info_wd.head  = head_inc;
                info_wd.fill  = info_rd_reg.fill - PW'(1);
            end
            default:
            begin
                info_we = 1'b0;
            end
        endcase
    end

    // Queue positions wrap around the slot's ring of WAITERS entries.
    assign rd_sum = (PW+1)'(info_rd_reg.head) + (PW+1)'(pos_reg);
    assign wr_sum = (PW+1)'(info_rd_reg.head) + (PW+1)'(info_rd_reg.fill);
    assign rd_ent = (rd_sum >= (PW+1)'(WAITERS)) ? HW'(rd_sum - (PW+1)'(WAITERS)) : HW'(rd_sum);
    assign wr_ent = (wr_sum >= (PW+1)'(WAITERS)) ? HW'(wr_sum - (PW+1)'(WAITERS)) : HW'(wr_sum);
    assign base    = AW'(slot_reg) * AW'(WAITERS);
    assign rd_addr = base + AW'(rd_ent);
    assign wr_addr = base + AW'(wr_ent);

    assign w_ok = ctrl.wrun && (pos_reg < info_rd_reg.fill);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg    <= '0;
            wq_vld_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.pos_clr)
            begin
                pos_reg <= '0;
            end
            else if (w_ok)
            begin
                pos_reg <= pos_reg + PW'(1);
            end
            wq_vld_reg <= w_ok;
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.act == ACT_ENQ)
        begin
            wmem[wr_addr] <= pid_reg;
        end
        if (w_ok)
        begin
            wq_data_reg <= wmem[rd_addr];
            wq_pos_reg  <= pos_reg;
        end
    end

    always_comb
    begin
        stat.cmd       = cmd_reg;
        stat.hit       = hit;
        stat.miss      = ctrl.scan_run && pr_vld_reg && !match
                         && (pr_idx_reg == SW'(NUM_SEMS - 1));
        stat.cnt_pos   = (info_rd_reg.count != '0);
        stat.fill_zero = (info_rd_reg.fill == '0);
        stat.fill_full = (info_rd_reg.fill == PW'(WAITERS));
        stat.post_wake = (new_post == ID_W'(1)) && (info_rd_reg.fill != '0);
        stat.wq_vld    = wq_vld_reg;
        stat.wq_last   = wq_vld_reg && (wq_pos_reg == info_rd_reg.fill - PW'(1));
        stat.dup_hit   = wq_vld_reg && (wq_data_reg == pid_reg);
        stat.dup_end   = stat.wq_last && (wq_data_reg != pid_reg);
    end

    always_comb
    begin
        done_next   = 1'b1;
        status_next = STAT_POSTED;
        rid_next    = id_reg;
        wpid_next   = '0;
        last_next   = 1'b1;
        case (ctrl.act)
            ACT_CREATE:
            begin
                status_next = STAT_CREATED;
                rid_next    = next_tag_reg;
            end
            ACT_TFULL:
            begin
                status_next = STAT_TABLEFULL;
                rid_next    = '0;
            end
            ACT_NFOUND:    status_next = STAT_NOTFOUND;
            ACT_GRANT:     status_next = STAT_GRANTED;
            ACT_BLOCK:     status_next = STAT_BLOCKED;
            ACT_ENQ:       status_next = STAT_BLOCKED;
            ACT_QFULL:     status_next = STAT_QUEUEFULL;
            ACT_POSTED:    status_next = STAT_POSTED;
            ACT_WAKE_POST:
            begin
                status_next = STAT_WOKEN;
                wpid_next   = wq_data_reg;
            end
            ACT_WAKE_KILL:
            begin
                status_next = STAT_WOKEN;
                wpid_next   = wq_data_reg;
                last_next   = 1'b0;
            end
            ACT_KILLED:    status_next = STAT_KILLED;
            default:
            begin
                done_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            done_reg     <= 1'b0;
            next_tag_reg <= '0;
        end
        else
        begin
            done_reg <= done_next;
            if (ctrl.act == ACT_CREATE)
            begin
                next_tag_reg <= next_tag_reg + ID_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        rid_reg    <= rid_next;
        wpid_reg   <= wpid_next;
        last_reg   <= last_next;
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign result_id   = rid_reg;
    assign woken_pid   = wpid_reg;
    assign last_of_run = last_reg;

    `CST_ASSERT(a_partial_is_woken, done_reg && !last_reg, status_reg == STAT_WOKEN, "non-final item is not a wake")
    `CST_ASSERT_NEXT(a_run_unbroken, done_reg && !last_reg, done_reg, "gap inside a kill run")
    `CST_ASSERT(a_created_tag, done_reg && status_reg == STAT_CREATED, rid_reg == next_tag_reg - ID_W'(1), "created id does not match tag counter")

endmodule

FILE: rtl/counting_semaphore_table.sv
// Top level of the counting semaphore table: controller plus datapath.
//
//   channel   handshake            fields
//   command   start / busy         command, target_id, process_id, initial_value
//   result    done (one cycle)     status, result_id, woken_pid, last_of_run
//
// The slot lookup probes one slot per cycle, and wait, post and kill then pass through
// a decision state. A wait on a zero count with waiters queued walks its waiter queue
// one entry per cycle; a waking post pops the queue head; kill reads its first waiter,
// then issues one woken item per cycle, then killed.
// Results are registered: each appears the cycle after it is decided, for one cycle.
// Reset clears the slot-in-use flags and the id counter; no clearing pass is needed.
// The receiver cannot stall, so busy depends only on the command in progress.
module counting_semaphore_table #(
    parameter int NUM_SEMS = cst_pkg::NUM_SEMS_DEF,
    parameter int WAITERS  = cst_pkg::WAITERS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [cst_pkg::CMD_W-1:0]     command,
    input  logic [cst_pkg::ID_W-1:0]      target_id,
    input  logic [cst_pkg::ID_W-1:0]      process_id,
    input  logic [cst_pkg::ID_W-1:0]      initial_value,
    output logic                          done,
    output logic [cst_pkg::STATUS_W-1:0]  status,
    output logic [cst_pkg::ID_W-1:0]      result_id,
    output logic [cst_pkg::ID_W-1:0]      woken_pid,
    output logic                          last_of_run
);
    import cst_pkg::*;

    ctrl_t    ctrl;
    dp_stat_t stat;

    cst_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .stat  (stat),
        .ctrl  (ctrl)
    );

    cst_dp #(
        .NUM_SEMS (NUM_SEMS),
        .WAITERS  (WAITERS)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .ctrl          (ctrl),
        .stat          (stat),
        .command       (command),
        .target_id     (target_id),
        .process_id    (process_id),
        .initial_value (initial_value),
        .done          (done),
        .status        (status),
        .result_id     (result_id),
        .woken_pid     (woken_pid),
        .last_of_run   (last_of_run)
    );

endmodule

FILE: tb/tb_top.sv
// Self-checking testbench for the counting semaphore table, with its own table predictor.
`timescale 1ns / 1ps

module tb_top;
    import cst_pkg::*;

    localparam int SEM_SLOTS = NUM_SEMS_DEF;
    localparam int QUEUE_DEPTH = WAITERS_DEF;
    localparam logic [ID_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct {
        status_t st;
        logic [ID_W-1:0] id;
        logic [ID_W-1:0] pid;
        logic last;
    } sem_answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic start = 1'b0;
    logic [CMD_W-1:0] command = '0;
    logic [ID_W-1:0] target_id = '0;
    logic [ID_W-1:0] process_id = '0;
    logic [ID_W-1:0] initial_value = '0;
    logic busy;
    logic done;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0] result_id;
    logic [ID_W-1:0] woken_pid;
    logic last_of_run;

    // Predicted table state.
    logic sem_used [SEM_SLOTS];
    logic [ID_W-1:0] sem_tag [SEM_SLOTS];
    logic [ID_W-1:0] sem_value [SEM_SLOTS];
    logic [ID_W-1:0] waiter_pid [SEM_SLOTS][QUEUE_DEPTH];
    int wq_head [SEM_SLOTS];
    int wq_fill [SEM_SLOTS];
    logic [ID_W-1:0] tag_counter;

    sem_answer_t pending_answers[$];
    int fail_count = 0;
    int gap_pct = 0;
    logic [ID_W-1:0] tag_a;
    logic [ID_W-1:0] tag_b;

    counting_semaphore_table dut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .target_id(target_id),
        .process_id(process_id),
        .initial_value(initial_value),
        .done(done),
        .status(status),
        .result_id(result_id),
        .woken_pid(woken_pid),
        .last_of_run(last_of_run)
    );

    initial
    begin
        forever #1 clk = ~clk;
    end

    function automatic void expect_answer(status_t st, logic [ID_W-1:0] id,
                                          logic [ID_W-1:0] pid, logic last);
        sem_answer_t a;
        a.st = st;
        a.id = id;
        a.pid = pid;
        a.last = last;
        pending_answers.push_back(a);
    endfunction

    function automatic int find_live_slot(logic [ID_W-1:0] tid);
        for (int s = 0; s < SEM_SLOTS; s++)
            if (sem_used[s] && sem_tag[s] == tid)
                return s;
        return -1;
    endfunction

    function automatic logic [ID_W-1:0] pop_waiter(int s);
        logic [ID_W-1:0] pid;
        pid = waiter_pid[s][wq_head[s]];
        wq_head[s] = (wq_head[s] + 1) % QUEUE_DEPTH;
        wq_fill[s]--;
        return pid;
    endfunction

    function automatic void predict_answers(cmd_t cmd, logic [ID_W-1:0] tid,
                                            logic [ID_W-1:0] pid, logic [ID_W-1:0] init);
        int s;
        logic dup;
        s = -1;
        dup = 1'b0;
        if (cmd == CMD_CREATE)
        begin
            for (int i = SEM_SLOTS - 1; i >= 0; i--)
                if (!sem_used[i])
                    s = i;
            if (s < 0)
            begin
                expect_answer(STAT_TABLEFULL, '0, '0, 1'b1);
                return;
            end
            sem_used[s] = 1'b1;
            sem_tag[s] = tag_counter;
            sem_value[s] = init;
            wq_head[s] = 0;
            wq_fill[s] = 0;
            tag_counter = tag_counter + 16'd1;
            expect_answer(STAT_CREATED, sem_tag[s], '0, 1'b1);
            return;
        end
        s = find_live_slot(tid);
        if (s < 0)
        begin
            expect_answer(STAT_NOTFOUND, tid, '0, 1'b1);
            return;
        end
        case (cmd)
            CMD_WAIT:
            begin
                for (int p = 0; p < wq_fill[s]; p++)
                    if (waiter_pid[s][(wq_head[s] + p) % QUEUE_DEPTH] == pid)
                        dup = 1'b1;
                if (sem_value[s] != 0)
                begin
                    sem_value[s] = sem_value[s] - 16'd1;
                    expect_answer(STAT_GRANTED, tid, '0, 1'b1);
                end
                else if (dup)
                    expect_answer(STAT_BLOCKED, tid, '0, 1'b1);
                else if (wq_fill[s] >= QUEUE_DEPTH)
                    expect_answer(STAT_QUEUEFULL, tid, '0, 1'b1);
                else
                begin
                    waiter_pid[s][(wq_head[s] + wq_fill[s]) % QUEUE_DEPTH] = pid;
                    wq_fill[s]++;
                    expect_answer(STAT_BLOCKED, tid, '0, 1'b1);
                end
            end
            CMD_POST:
            begin
                if (sem_value[s] != COUNT_MAX)
                    sem_value[s] = sem_value[s] + 16'd1;
                // The count stays at one after a wake; the woken process waits again.
                if (sem_value[s] == 16'd1 && wq_fill[s] > 0)
                    expect_answer(STAT_WOKEN, tid, pop_waiter(s), 1'b1);
                else
                    expect_answer(STAT_POSTED, tid, '0, 1'b1);
            end
            default:
            begin
                while (wq_fill[s] > 0)
                    expect_answer(STAT_WOKEN, tid, pop_waiter(s), 1'b0);
                sem_used[s] = 1'b0;
                wq_head[s] = 0;
                expect_answer(STAT_KILLED, tid, '0, 1'b1);
            end
        endcase
    endfunction

    function automatic logic [ID_W-1:0] live_tag();
        int picks[$];
        foreach (sem_used[i])
            if (sem_used[i])
                picks.push_back(i);
        if (picks.size() == 0)
            return ID_W'($urandom);
        return sem_tag[picks[$urandom_range(picks.size() - 1)]];
    endfunction

    // Drives one item at the falling edge, after an optional idle gap, and holds it until the block is idle again.
    task automatic send_item(cmd_t cmd, logic [ID_W-1:0] tid, logic [ID_W-1:0] pid,
                             logic [ID_W-1:0] init);
        int gap;
        gap = ($urandom_range(99) < gap_pct) ? $urandom_range(1, 5) : 0;
        @(negedge clk);
        if (gap != 0)
        begin
            start = 1'b0;
            repeat (gap) @(negedge clk);
        end
        start = 1'b1;
        command = cmd;
        target_id = tid;
        process_id = pid;
        initial_value = init;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        predict_answers(cmd, tid, pid, init);
    endtask

    always @(posedge clk)
    begin : answer_check
        sem_answer_t want;
        if (rst_n && done === 1'b1)
        begin
            if (pending_answers.size() == 0)
            begin
                $error("unexpected result: status %0d, result_id %0h", status, result_id);
                fail_count++;
            end
            else
            begin
                want = pending_answers.pop_front();
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    fail_count++;
                end
                if (result_id !== want.id)
                begin
                    $error("result_id: expected %0h, got %0h", want.id, result_id);
                    fail_count++;
                end
                if (woken_pid !== want.pid)
                begin
                    $error("woken_pid: expected %0h, got %0h", want.pid, woken_pid);
                    fail_count++;
                end
                if (last_of_run !== want.last)
                begin
                    $error("last_of_run: expected %0b, got %0b", want.last, last_of_run);
                    fail_count++;
                end
            end
        end
    end

    task automatic test_create_until_full();
        gap_pct = 0;
        tag_a = tag_counter;
        send_item(CMD_CREATE, 16'hFFFF, 16'hFFFF, 16'h0000);
        tag_b = tag_counter;
        send_item(CMD_CREATE, 16'h0000, 16'h0000, COUNT_MAX);
        for (int i = 0; i < SEM_SLOTS - 2; i++)
            send_item(CMD_CREATE, 16'h0000, 16'h0000, ID_W'(i + 1));
        send_item(CMD_CREATE, 16'h0000, 16'h0000, 16'h5555);
    endtask

    task automatic test_wait_queue();
        send_item(CMD_WAIT, tag_a, 16'h0000, 16'hFFFF);
        // The same process waiting again must not take a second queue entry.
        send_item(CMD_WAIT, tag_a, 16'h0000, 16'h0000);
        for (int i = 1; i < QUEUE_DEPTH; i++)
            send_item(CMD_WAIT, tag_a, ID_W'((i << 12) | i), 16'h0000);
        send_item(CMD_WAIT, tag_a, 16'hFFFF, 16'h0000);
        send_item(CMD_WAIT, tag_b, 16'hFFFF, 16'h0000);
    endtask

    task automatic test_post_wake_and_saturate();
        send_item(CMD_POST, tag_a, 16'h0000, 16'h0000);
        send_item(CMD_WAIT, tag_a, 16'hABCD, 16'h0000);
        send_item(CMD_WAIT, tag_a, 16'h8000, 16'h0000);
        send_item(CMD_POST, tag_b, 16'h0000, 16'h0000);
        send_item(CMD_POST, tag_b, 16'h0000, 16'h0000);
    endtask

    task automatic test_unknown_ids();
        send_item(CMD_WAIT, 16'hFFFF, 16'h0001, 16'h0000);
        send_item(CMD_POST, 16'hAAAA, 16'h0000, 16'h0000);
        send_item(CMD_KILL, 16'h5555, 16'h0000, 16'h0000);
    endtask

    task automatic test_kill_drains_queue();
        send_item(CMD_KILL, tag_a, 16'h0000, 16'h0000);
        send_item(CMD_KILL, tag_b, 16'h0000, 16'h0000);
    endtask

    task automatic test_random_traffic(int count, int idle_pct);
        cmd_t cmd;
        logic [ID_W-1:0] tid;
        logic [ID_W-1:0] pid;
        logic [ID_W-1:0] init;
        int live;
        int roll;
        gap_pct = idle_pct;
        repeat (count)
        begin
            live = 0;
            foreach (sem_used[i])
                if (sem_used[i])
                    live++;
            roll = $urandom_range(99);
            if ((live < 3 && roll < 50) || roll < 15)
                cmd = CMD_CREATE;
            else if (roll < 55)
                cmd = CMD_WAIT;
            else if (roll < 88)
                cmd = CMD_POST;
            else
                cmd = CMD_KILL;
            if ($urandom_range(99) < 85)
                tid = live_tag();
            else
                tid = ID_W'($urandom);
            // A small pid pool makes repeated waits by the same process common.
            if ($urandom_range(99) < 70)
                pid = ID_W'($urandom_range(0, 9));
            else
                pid = ID_W'($urandom);
            case ($urandom_range(3))
                0, 1: init = ID_W'($urandom_range(0, 2));
                2: init = COUNT_MAX - ID_W'($urandom_range(0, 1));
                default: init = ID_W'($urandom);
            endcase
            send_item(cmd, tid, pid, init);
        end
    endtask

    initial
    begin
        for (int s = 0; s < SEM_SLOTS; s++)
        begin
            sem_used[s] = 1'b0;
            wq_head[s] = 0;
            wq_fill[s] = 0;
        end
        tag_counter = '0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_create_until_full();
        test_wait_queue();
        test_post_wake_and_saturate();
        test_unknown_ids();
        test_kill_drains_queue();
        test_random_traffic(170, 0);
        test_random_traffic(170, 67);
        test_random_traffic(170, 19);

        @(negedge clk);
        start = 1'b0;
        while (pending_answers.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
        if (fail_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

    // Ends the run as a failure if it has not finished within this bound, which leaves wide margin.
    initial
    begin
        #10_000_000;
        $display("status: fail");
        $finish;
    end

endmodule

FILE: files.f
+incdir+rtl
rtl/cst_pkg.sv
rtl/cst_ctrl.sv
rtl/cst_dp.sv
rtl/counting_semaphore_table.sv
tb/tb_top.sv
